FILE: rtl/dual_free_list_slot_pool_defines.svh
// assertion macros for the dual free-list slot pool
// used by dual_free_list_slot_pool.sv; the macros expect clk and arst_n in scope
`ifndef DUAL_FREE_LIST_SLOT_POOL_DEFINES_SVH
`define DUAL_FREE_LIST_SLOT_POOL_DEFINES_SVH

// same-cycle implication, off while in reset
`define DFSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfsp: same-cycle check failed");

// next-cycle implication, off while in reset
`define DFSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfsp: next-cycle check failed");

`endif

FILE: rtl/dfsp_pkg.sv
// package for the dual free-list slot pool: sequencer states and codes
// no dependencies
package dfsp_pkg;

	// fixed field widths
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CNT_IN_W  = 7;
	localparam int unsigned CFG_IDX_W = 2;

	// operation codes
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_USED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_USED = 2'd1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_TAIL
	} st_t;

endpackage

FILE: rtl/dual_free_list_slot_pool.sv
// dual free-list slot pool: fifo body list and lifo controller list in two link memories
// depends on dfsp_pkg and dual_free_list_slot_pool_defines.svh
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid / in_stall | operation, body_index, controller_index
//  out     | out       | out_valid/out_stall | success, granted_body, granted_controller
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// an acquire or a failed release reads both link memories when the beat is accepted and
// updates them in the exec state; a successful release into a non-empty body list also
// takes a tail state for the tail link write on the body memory port. after reset and each
// count write, a sweep over all POOL_SIZE entries rebuilds the link memories, with no
// beat accepted. the update waits while a stalled result sits in the output register.
`include "dual_free_list_slot_pool_defines.svh"

module dual_free_list_slot_pool #(
	parameter int unsigned POOL_SIZE = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dfsp_pkg::CNT_IN_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [dfsp_pkg::IDX_W-1:0]      body_index,
	input  logic [dfsp_pkg::IDX_W-1:0]      controller_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            success,
	output logic [dfsp_pkg::IDX_W-1:0]      granted_body,
	output logic [dfsp_pkg::IDX_W-1:0]      granted_controller
);
	import dfsp_pkg::*;

	localparam int unsigned IW = $clog2(POOL_SIZE);
	localparam int unsigned LW = $clog2(POOL_SIZE + 1);
	localparam logic [LW-1:0] NULL_SLOT = LW'(POOL_SIZE);
	localparam logic [LW-1:0] RST_CNT   = LW'((POOL_SIZE < 64) ? POOL_SIZE : 64);

	// memory entry: live bit on top, link below
	logic [LW:0] body_mem [POOL_SIZE];
	logic [LW:0] ctrl_mem [POOL_SIZE];
	logic [LW:0] body_rd_q, ctrl_rd_q;

	st_t state_q, state_d;
	logic [IW-1:0]    sweep_q;
	logic [LW-1:0]    body_cnt_q, ctrl_cnt_q;
	logic [LW-1:0]    body_head_q, body_tail_q, ctrl_head_q;
	logic [IW-1:0]    tail_fix_q;
	logic             op_q;
	logic [IDX_W-1:0] body_idx_q, ctrl_idx_q;
	logic [IW-1:0]    body_slot_q, ctrl_slot_q;
	logic             out_valid_q, success_q;
	logic [IDX_W-1:0] granted_body_q, granted_ctrl_q;

	logic          accept, out_free, commit, acq_ok, rel_ok, op_ok;
	logic          rebuild;
	logic [LW-1:0] cfg_cnt, new_body_cnt, new_ctrl_cnt, sweep_nxt;
	logic [IW-1:0] body_raddr, ctrl_raddr;
	logic          bw_en, cw_en;
	logic [IW-1:0] bw_addr, cw_addr;
	logic [LW:0]   bw_data, cw_data;

	// clamp the written count and pick the counts the rebuild uses
	always_comb begin
		cfg_cnt = (int'(cfg_data) > int'(POOL_SIZE)) ? NULL_SLOT : LW'(cfg_data);
		rebuild = cfg_we && ((cfg_index == CFG_BODY_USED) || (cfg_index == CFG_CTRL_USED));
		new_body_cnt = (cfg_we && (cfg_index == CFG_BODY_USED)) ? cfg_cnt : body_cnt_q;
		new_ctrl_cnt = (cfg_we && (cfg_index == CFG_CTRL_USED)) ? cfg_cnt : ctrl_cnt_q;
	end

	// datapath decisions and memory write ports
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		accept     = in_valid && !in_stall;
		out_free   = !out_valid_q || !out_stall;
		acq_ok     = (body_head_q != NULL_SLOT) && (ctrl_head_q != NULL_SLOT);
		rel_ok     = (int'(body_idx_q) < int'(body_cnt_q))
		          && (int'(ctrl_idx_q) < int'(ctrl_cnt_q))
		          && body_rd_q[LW] && ctrl_rd_q[LW];
		op_ok      = (op_q == OP_RELEASE) ? rel_ok : acq_ok;
		commit     = (state_q == ST_EXEC) && out_free;
		body_raddr = (operation == OP_RELEASE) ? IW'(body_index) : IW'(body_head_q);
		ctrl_raddr = (operation == OP_RELEASE) ? IW'(controller_index) : IW'(ctrl_head_q);
		sweep_nxt  = LW'(sweep_q) + LW'(1);
		bw_en   = 1'b0;
		bw_addr = '0;
		bw_data = '0;
		cw_en   = 1'b0;
		cw_addr = '0;
		cw_data = '0;
		unique case (state_q)
			ST_INIT: begin
				bw_en   = 1'b1;
				bw_addr = sweep_q;
				bw_data = {1'b0, (sweep_nxt < body_cnt_q) ? sweep_nxt : NULL_SLOT};
				cw_en   = 1'b1;
				cw_addr = sweep_q;
				cw_data = {1'b0, (sweep_nxt < ctrl_cnt_q) ? sweep_nxt : NULL_SLOT};
			end
			ST_EXEC: begin
				if (commit && op_ok) begin
					bw_en   = 1'b1;
					bw_addr = body_slot_q;
					cw_en   = 1'b1;
					cw_addr = ctrl_slot_q;
					if (op_q == OP_RELEASE) begin
						bw_data = {1'b0, NULL_SLOT};
						cw_data = {1'b0, ctrl_head_q};
					end else begin
						bw_data = {1'b1, NULL_SLOT};
						cw_data = {1'b1, NULL_SLOT};
					end
				end
			end
			ST_TAIL: begin
				bw_en   = 1'b1;
				bw_addr = tail_fix_q;
				bw_data = {1'b0, LW'(body_slot_q)};
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: if (sweep_q == IW'(POOL_SIZE - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_EXEC;
			ST_EXEC: begin
				if (commit) begin
					if ((op_q == OP_RELEASE) && rel_ok && (body_tail_q != NULL_SLOT)) begin
						state_d = ST_TAIL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TAIL: state_d = ST_IDLE;
			default: state_d = ST_INIT;
		endcase
		if (rebuild) state_d = ST_INIT;
	end

	// link memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (bw_en) body_mem[bw_addr] <= bw_data;
		if (accept) body_rd_q <= body_mem[body_raddr];
	end

	always_ff @(posedge clk) begin
		if (cw_en) ctrl_mem[cw_addr] <= cw_data;
		if (accept) ctrl_rd_q <= ctrl_mem[ctrl_raddr];
	end

	// captured input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= operation;
			body_idx_q  <= body_index;
			ctrl_idx_q  <= controller_index;
			body_slot_q <= body_raddr;
			ctrl_slot_q <= ctrl_raddr;
		end
	end

	// sequencer, counts and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			body_cnt_q  <= RST_CNT;
			ctrl_cnt_q  <= RST_CNT;
			body_head_q <= (RST_CNT != '0) ? '0 : NULL_SLOT;
			body_tail_q <= (RST_CNT != '0) ? RST_CNT - LW'(1) : NULL_SLOT;
			ctrl_head_q <= (RST_CNT != '0) ? '0 : NULL_SLOT;
			tail_fix_q  <= '0;
		end else begin
			state_q <= state_d;
			if (rebuild) begin
				sweep_q     <= '0;
				body_cnt_q  <= new_body_cnt;
				ctrl_cnt_q  <= new_ctrl_cnt;
				body_head_q <= (new_body_cnt != '0) ? '0 : NULL_SLOT;
				body_tail_q <= (new_body_cnt != '0) ? new_body_cnt - LW'(1) : NULL_SLOT;
				ctrl_head_q <= (new_ctrl_cnt != '0) ? '0 : NULL_SLOT;
			end else begin
				if (state_q == ST_INIT) sweep_q <= sweep_q + IW'(1);
				if (commit && op_ok) begin
					if (op_q == OP_RELEASE) begin
						// fifo append at the tail, lifo push at the head
						if (body_tail_q == NULL_SLOT) body_head_q <= LW'(body_slot_q);
						tail_fix_q  <= IW'(body_tail_q);
						body_tail_q <= LW'(body_slot_q);
						ctrl_head_q <= LW'(ctrl_slot_q);
					end else begin
						// pop both heads
						body_head_q <= body_rd_q[LW-1:0];
						if (body_rd_q[LW-1:0] == NULL_SLOT) body_tail_q <= NULL_SLOT;
						ctrl_head_q <= ctrl_rd_q[LW-1:0];
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			success_q <= op_ok;
			if ((op_q == OP_ACQUIRE) && acq_ok) begin
				granted_body_q <= IDX_W'(body_slot_q);
				granted_ctrl_q <= IDX_W'(ctrl_slot_q);
			end else begin
				granted_body_q <= '0;
				granted_ctrl_q <= '0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign success            = success_q;
	assign granted_body       = granted_body_q;
	assign granted_controller = granted_ctrl_q;

	// checks
	`DFSP_ASSERT_NEXT(a_accept_to_exec, accept && !cfg_we, state_q == ST_EXEC)
	`DFSP_ASSERT_IMP(a_body_ends_agree, 1'b1, (body_head_q == NULL_SLOT) == (body_tail_q == NULL_SLOT))
	`DFSP_ASSERT_IMP(a_fail_no_grant, out_valid_q && !success_q, (granted_body_q == '0) && (granted_ctrl_q == '0))

endmodule
